[src/fp2r_pkg.sv]
`timescale 1ns / 1ps

package fp2r_pkg;

  localparam int STAGES = 6;

  typedef enum logic [1:0] {
    CLS_PASS = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_ONE  = 2'd2
  } cls_t;

  typedef struct packed {
    logic [STAGES-1:0] en;
  } pipe_ctl_t;

  localparam logic [49:0] HALF_FIX = 50'h2_0000_0000_0000;
  localparam logic [7:0]  EXP_ONE  = 8'd127;
  localparam logic [7:0]  EXP_MAX  = 8'hFF;
  localparam logic [7:0]  EXP_MIN_DIRECT = 8'd118;
  localparam logic [7:0]  EXP_MIN_HALVED = 8'd102;
  localparam logic [7:0]  SHIFT_DIRECT = 8'd100;
  localparam logic [7:0]  SHIFT_HALVED = 8'd101;
  localparam logic [7:0]  BYTE_FULL = 8'hFF;

endpackage

[src/float_pixel_to_rgba8.sv]
`timescale 1ns / 1ps
// Float pixel to RGBA8 converter.
// Input channel: in_valid / in_stall with red_value, green_value, blue_value
// as binary32 patterns. Output channel: out_valid / out_stall with red_byte,
// green_byte, blue_byte and alpha_byte (always 255). A word moves at a clock
// edge where valid is high and stall is low.
// range_mode (cfg_we / cfg_data): 0 maps -1..1, 1 maps 0..1; write it only
// when the pipeline is empty.
// A word passes through six registered stages from input acceptance to
// out_valid. One word per cycle is taken and delivered while out_stall is
// low, set by the six-stage datapath (decode, leading zero count,
// normalise/round, times 255, round, byte round).
// Stages advance independently, so empty stages fill while the output is
// stalled; in_stall rises only when all six stages hold a word and out_stall
// is high.
// Synchronous reset empties the pipeline and sets range_mode to 0.
module float_pixel_to_rgba8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] red_value,
  input  logic [31:0] green_value,
  input  logic [31:0] blue_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_byte,
  output logic [7:0]  green_byte,
  output logic [7:0]  blue_byte,
  output logic [7:0]  alpha_byte
);

  logic                range_mode;
  fp2r_pkg::pipe_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode <= 1'b0;
    end else if (cfg_we) begin
      range_mode <= cfg_data;
    end
  end

  fp2r_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  fp2r_lane u_red (
    .clk        (clk),
    .ctl        (ctl),
    .range_mode (range_mode),
    .value      (red_value),
    .byte_out   (red_byte)
  );

  fp2r_lane u_green (
    .clk        (clk),
    .ctl        (ctl),
    .range_mode (range_mode),
    .value      (green_value),
    .byte_out   (green_byte)
  );

  fp2r_lane u_blue (
    .clk        (clk),
    .ctl        (ctl),
    .range_mode (range_mode),
    .value      (blue_value),
    .byte_out   (blue_byte)
  );

  assign alpha_byte = fp2r_pkg::BYTE_FULL;

endmodule

[src/fp2r_ctrl.sv]
`timescale 1ns / 1ps

module fp2r_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fp2r_pkg::pipe_ctl_t  ctl
);

  localparam int N = fp2r_pkg::STAGES;

  logic [N-1:0] vld;
  logic [N-1:0] vld_next;
  logic [N-1:0] move;

  always_comb begin
    move[N-1] = !vld[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      move[i] = !vld[i] || move[i+1];
    end
    vld_next[0] = move[0] ? in_valid : vld[0];
    for (int i = 1; i < N; i++) begin
      vld_next[i] = move[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall  = !move[0];
  assign out_valid = vld[N-1];
  assign ctl.en    = move;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled with an empty stage");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    ((~move & ~vld) == '0))
    else $error("empty stage held");

  a_count: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ($countones(vld) == $countones($past(vld))
               + ($past(in_valid && !in_stall) ? 1 : 0)
               - ($past(out_valid && !out_stall) ? 1 : 0)))
    else $error("word lost or repeated");

endmodule

[src/fp2r_lane.sv]
`timescale 1ns / 1ps

module fp2r_lane (
  input  logic                clk,
  input  fp2r_pkg::pipe_ctl_t ctl,
  input  logic                range_mode,
  input  logic [31:0]         value,
  output logic [7:0]          byte_out
);

  // stage 1: decode, align to 50 fraction bits, add the half bias in mode 0
  logic              sgn;
  logic [7:0]        ex_in;
  logic [23:0]       man_in;
  logic              nan_in;
  logic [7:0]        sh_full;
  logic [49:0]       x_fix;
  fp2r_pkg::cls_t    cls_d;
  logic [49:0]       t_d;

  fp2r_pkg::cls_t    cls1;
  logic [49:0]       t1;

  always_comb begin
    sgn     = value[31];
    ex_in   = value[30:23];
    man_in  = {|ex_in, value[22:0]};
    nan_in  = (ex_in == fp2r_pkg::EXP_MAX) && (|value[22:0]);
    sh_full = range_mode ? (ex_in - fp2r_pkg::SHIFT_DIRECT)
                         : (ex_in - fp2r_pkg::SHIFT_HALVED);
    x_fix   = {26'd0, man_in} << sh_full[4:0];
    cls_d   = fp2r_pkg::CLS_PASS;
    t_d     = x_fix;
    if (nan_in) begin
      cls_d = fp2r_pkg::CLS_ZERO;
    end else if (range_mode) begin
      if (sgn || ex_in < fp2r_pkg::EXP_MIN_DIRECT) begin
        cls_d = fp2r_pkg::CLS_ZERO;
      end else if (ex_in >= fp2r_pkg::EXP_ONE) begin
        cls_d = fp2r_pkg::CLS_ONE;
      end
    end else begin
      if (ex_in >= fp2r_pkg::EXP_ONE) begin
        cls_d = sgn ? fp2r_pkg::CLS_ZERO : fp2r_pkg::CLS_ONE;
      end else if (ex_in < fp2r_pkg::EXP_MIN_HALVED) begin
        t_d = fp2r_pkg::HALF_FIX;
      end else begin
        t_d = sgn ? (fp2r_pkg::HALF_FIX - x_fix) : (fp2r_pkg::HALF_FIX + x_fix);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      cls1 <= cls_d;
      t1   <= t_d;
    end
  end

  // stage 2: leading zero count
  logic [5:0]     lz_d;
  fp2r_pkg::cls_t cls2;
  logic [49:0]    t2;
  logic [5:0]     lz2;

  always_comb begin
    lz_d = '0;
    for (int i = 0; i < 50; i++) begin
      if (t1[i]) begin
        lz_d = 6'(49 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      cls2 <= cls1;
      t2   <= t1;
      lz2  <= lz_d;
    end
  end

  // stage 3: normalise and round to single precision
  logic [49:0]    n_fix;
  logic [24:0]    m_sum;
  logic           m_up;
  fp2r_pkg::cls_t cls_r;
  logic [23:0]    m_r;
  logic [5:0]     e_r;
  fp2r_pkg::cls_t cls3;
  logic [23:0]    m3;
  logic [5:0]     e3;

  always_comb begin
    n_fix = t2 << lz2;
    m_up  = n_fix[25] && ((|n_fix[24:0]) || n_fix[26]);
    m_sum = {1'b0, n_fix[49:26]} + {24'd0, m_up};
    cls_r = cls2;
    m_r   = m_sum[23:0];
    e_r   = lz2;
    if (m_sum[24]) begin
      m_r = 24'h80_0000;
      e_r = lz2 - 6'd1;
      if (lz2 == 6'd0 && cls2 == fp2r_pkg::CLS_PASS) begin
        cls_r = fp2r_pkg::CLS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      cls3 <= cls_r;
      m3   <= m_r;
      e3   <= e_r;
    end
  end

  // stage 4: times 255
  fp2r_pkg::cls_t cls4;
  logic [31:0]    p4;
  logic [5:0]     e4;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      cls4 <= cls3;
      p4   <= ({8'd0, m3} << 8) - {8'd0, m3};
      e4   <= e3;
    end
  end

  // stage 5: round product to single precision
  logic [23:0]    q_raw;
  logic           q_up;
  logic [24:0]    q_sum;
  logic [3:0]     base;
  logic [23:0]    q_r;
  logic signed [6:0] k_r;
  fp2r_pkg::cls_t cls5;
  logic [23:0]    q5;
  logic signed [6:0] k5;

  always_comb begin
    if (p4[31]) begin
      q_raw = p4[31:8];
      q_up  = p4[7] && ((|p4[6:0]) || p4[8]);
      base  = 4'd9;
    end else begin
      q_raw = p4[30:7];
      q_up  = p4[6] && ((|p4[5:0]) || p4[7]);
      base  = 4'd8;
    end
    q_sum = {1'b0, q_raw} + {24'd0, q_up};
    q_r   = q_sum[23:0];
    if (q_sum[24]) begin
      q_r  = 24'h80_0000;
      base = base + 4'd1;
    end
    k_r = $signed({3'd0, base}) - $signed({1'b0, e4});
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      cls5 <= cls4;
      q5   <= q_r;
      k5   <= k_r;
    end
  end

  // stage 6: round half up to a byte
  logic [34:0] s_fix;
  logic [34:0] s_rnd;
  logic [9:0]  b_whole;
  logic [6:0]  k_neg;
  logic [7:0]  byte_d;

  always_comb begin
    k_neg = 7'(-k5);
    if (k5 >= 0) begin
      s_fix = {11'd0, q5} << k5[3:0];
    end else begin
      s_fix = {11'd0, q5} >> k_neg[5:0];
    end
    s_rnd   = s_fix + 35'h100_0000;
    b_whole = s_rnd[34:25];
    case (cls5)
      fp2r_pkg::CLS_ZERO: byte_d = 8'd0;
      fp2r_pkg::CLS_ONE:  byte_d = fp2r_pkg::BYTE_FULL;
      fp2r_pkg::CLS_PASS: byte_d = (b_whole >= 10'd255) ? fp2r_pkg::BYTE_FULL
                                                        : b_whole[7:0];
      default:            byte_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      byte_out <= byte_d;
    end
  end

endmodule
